// ===== hdl/mda_pkg.sv =====
// Shared types and constants for the row-major array store.
// No dependencies; imported by multidim_array_access and mda_checker.
package mda_pkg;

   localparam int IDX_FIELDS = 4;                  // index fields per word
   localparam int CUR_W      = $clog2(IDX_FIELDS);  // dimension cursor
   localparam int INDEX_W    = 12;
   localparam int LEN_W      = 13;
   localparam int DIMS_W     = 3;
   localparam int WORD_W     = 32;                  // read_data / write_data
   localparam int STATUS_W   = 2;
   localparam int OFFSET_W   = 12;

   localparam int REQ_DATA_W = IDX_FIELDS * INDEX_W + WORD_W;        // 80
   localparam int RSP_BITS   = WORD_W + STATUS_W + OFFSET_W;         // 46
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;             // 48
   localparam int REQ_USER_W = 1;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIMS_W-1:0] NUM_DIMS_RESET = DIMS_W'(1);
   localparam logic [LEN_W-1:0]  LEN0_RESET     = LEN_W'(4096);
   localparam logic [LEN_W-1:0]  LEN_RESET      = LEN_W'(1);

   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_RANGE    = 2'd1,
      STATUS_CAPACITY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_NUM_DIMS = 3'd0,
      REG_LENGTH_0 = 3'd1,
      REG_LENGTH_1 = 3'd2,
      REG_LENGTH_2 = 3'd3,
      REG_LENGTH_3 = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      SS_IDLE,
      SS_INIT,
      SS_RUN
   } stride_state_type;

endpackage

// ===== hdl/mda_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module mda_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/multidim_array_access.sv =====
// Top level of the row-major N-dimensional array store.
// Depends on mda_pkg and mda_ram.
//
//   channel | dir | handshake              | word contents
//   --------+-----+------------------------+-----------------------------------------
//   req_    | in  | tvalid/tready          | tdata: index_0..3, write_data; tuser: mode
//   rsp_    | out | tvalid/tready          | tdata: read_data, status, offset
//   csr_    | in  | APB, pready always 1   | num_dims @0x00, length_0..3 @0x04..0x10
//
// One word per cycle while rsp_tready stays high and no stride rebuild runs; a result
// passes the multiply, sum, bounds and RAM read registers on its way to rsp_, the first
// loaded at the edge that takes its request.
// rsp_tready low with a word waiting freezes the whole pipe; the RAM read register
// holds its data.
// A register write rebuilds the stride table with one multiplier, through the INIT state
// and, for more than one dimension, the RUN state, during which req_tready is low.
// Reset: num_dims 1, length_0 4096, others 1, strides {1,0,0,0}; no clearing pass,
// array contents are undefined until written.
module multidim_array_access
   import mda_pkg::*;
#(
   parameter int MAX_DIMS   = 4,
   parameter int MEM_DEPTH  = 4096,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // index_0, index_1, index_2, index_3, write_data
   input  logic [REQ_USER_W-1:0] req_tuser,  // mode
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // read_data, status, offset, zero pad
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int SW        = $clog2(MEM_DEPTH + 1);   // stride saturates at MEM_DEPTH
   localparam int PROD_W    = SW + INDEX_W;
   localparam int SUM_W     = PROD_W + CUR_W;
   localparam int MUL_W     = SW + LEN_W;
   localparam int DIM_LIMIT = (MAX_DIMS < IDX_FIELDS) ? MAX_DIMS : IDX_FIELDS;

   // ---------------------------------------------------------------- registers
   logic [DIMS_W-1:0] num_dims_ff;
   logic [LEN_W-1:0]  len_ff [IDX_FIELDS];
   logic              csr_wr;
   logic              cfg_hit;
   reg_index_type     csr_index;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      cfg_hit = 1'b0;
      unique case (csr_index) inside
         REG_NUM_DIMS, REG_LENGTH_0, REG_LENGTH_1, REG_LENGTH_2, REG_LENGTH_3: begin
            cfg_hit = csr_wr;
         end
         default: begin
            cfg_hit = 1'b0;   // unmapped, write dropped
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= NUM_DIMS_RESET;
         len_ff[0]   <= LEN0_RESET;
         for (int i = 1; i < IDX_FIELDS; i++) begin
            len_ff[i] <= LEN_RESET;
         end
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_NUM_DIMS: num_dims_ff <= csr_pwdata[DIMS_W-1:0];
            REG_LENGTH_0: len_ff[0]   <= csr_pwdata[LEN_W-1:0];
            REG_LENGTH_1: len_ff[1]   <= csr_pwdata[LEN_W-1:0];
            REG_LENGTH_2: len_ff[2]   <= csr_pwdata[LEN_W-1:0];
            REG_LENGTH_3: len_ff[3]   <= csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_NUM_DIMS: csr_prdata = CSR_DATA_W'(num_dims_ff);
         REG_LENGTH_0: csr_prdata = CSR_DATA_W'(len_ff[0]);
         REG_LENGTH_1: csr_prdata = CSR_DATA_W'(len_ff[1]);
         REG_LENGTH_2: csr_prdata = CSR_DATA_W'(len_ff[2]);
         REG_LENGTH_3: csr_prdata = CSR_DATA_W'(len_ff[3]);
         default:      csr_prdata = '0;
      endcase
   end

   // dimension count clamped to 1..DIM_LIMIT
   logic [DIMS_W-1:0] dims_used;

   always_comb begin
      if (num_dims_ff == '0) begin
         dims_used = DIMS_W'(1);
      end else if (num_dims_ff > DIMS_W'(DIM_LIMIT)) begin
         dims_used = DIMS_W'(DIM_LIMIT);
      end else begin
         dims_used = num_dims_ff;
      end
   end

   // ------------------------------------------------------- stride sequencer
   // INIT: innermost used stride = 1, the rest 0. RUN: walk outward, one
   // saturating multiply per cycle.
   stride_state_type  stride_state_ff, stride_state_in;
   logic [SW-1:0]     stride_ff [IDX_FIELDS];
   logic [CUR_W-1:0]  cursor_ff;
   logic [CUR_W-1:0]  cursor_prev;
   logic [MUL_W-1:0]  stride_mul;
   logic [SW-1:0]     stride_sat;
   logic              seq_busy, seq_init, seq_step;

   always_comb begin
      stride_state_in = stride_state_ff;
      unique case (stride_state_ff)
         SS_IDLE: begin
            if (cfg_hit) stride_state_in = SS_INIT;
         end
         SS_INIT: begin
            if (cfg_hit)                         stride_state_in = SS_INIT;
            else if (dims_used == DIMS_W'(1))    stride_state_in = SS_IDLE;
            else                                 stride_state_in = SS_RUN;
         end
         SS_RUN: begin
            if (cfg_hit)                         stride_state_in = SS_INIT;
            else if (cursor_ff == CUR_W'(1))     stride_state_in = SS_IDLE;
            else                                 stride_state_in = SS_RUN;
         end
         default: stride_state_in = SS_IDLE;
      endcase
   end

   always_comb begin
      seq_busy = 1'b1;
      seq_init = 1'b0;
      seq_step = 1'b0;
      unique case (stride_state_ff)
         SS_IDLE: seq_busy = 1'b0;
         SS_INIT: seq_init = 1'b1;
         SS_RUN:  seq_step = 1'b1;
         default: seq_busy = 1'b0;
      endcase
   end

   assign cursor_prev = cursor_ff - 1'b1;
   assign stride_mul  = MUL_W'(len_ff[cursor_ff]) * MUL_W'(stride_ff[cursor_ff]);
   assign stride_sat  = (stride_mul > MUL_W'(MEM_DEPTH)) ? SW'(MEM_DEPTH)
                                                          : stride_mul[SW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_state_ff <= SS_IDLE;
         cursor_ff       <= '0;
         stride_ff[0]    <= SW'(1);
         for (int i = 1; i < IDX_FIELDS; i++) begin
            stride_ff[i] <= '0;
         end
      end else begin
         stride_state_ff <= stride_state_in;
         if (seq_init) begin
            cursor_ff <= CUR_W'(dims_used - 1'b1);
            for (int i = 0; i < IDX_FIELDS; i++) begin
               stride_ff[i] <= (DIMS_W'(i) == dims_used - 1'b1) ? SW'(1) : '0;
            end
         end else if (seq_step) begin
            cursor_ff              <= cursor_prev;
            stride_ff[cursor_prev] <= stride_sat;
         end
      end
   end

   // --------------------------------------------------------------- pipeline
   logic adv, req_acc;

   assign adv        = ~rsp_tvalid | rsp_tready;
   assign req_tready = adv & ~seq_busy;
   assign req_acc    = req_tvalid & req_tready;

   // stage 1 inputs: bounds check and one product per dimension
   logic [INDEX_W-1:0] req_index [IDX_FIELDS];
   logic [PROD_W-1:0]  prod_in   [IDX_FIELDS];
   logic               oob_in;

   always_comb begin
      oob_in = 1'b0;
      for (int i = 0; i < IDX_FIELDS; i++) begin
         req_index[i] = req_tdata[i*INDEX_W +: INDEX_W];
         prod_in[i]   = PROD_W'(stride_ff[i]) * PROD_W'(req_index[i]);
         if ((DIMS_W'(i) < dims_used) && ({1'b0, req_index[i]} >= len_ff[i])) begin
            oob_in = 1'b1;
         end
      end
   end

   logic               s1_v_ff, s2_v_ff, s3_v_ff, rsp_v_ff;
   logic [PROD_W-1:0]  s1_prod_ff [IDX_FIELDS];
   logic               s1_oob_ff, s1_mode_ff;
   logic [WORD_W-1:0]  s1_wdata_ff;
   logic [SUM_W-1:0]   s2_sum_ff, sum_in;
   logic               s2_oob_ff, s2_mode_ff;
   logic [WORD_W-1:0]  s2_wdata_ff;
   status_type         s3_status_ff, status_in;
   logic [AW-1:0]      s3_addr_ff;
   logic               s3_mode_ff;
   logic [WORD_W-1:0]  s3_wdata_ff;
   status_type         rsp_status_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic               rsp_rd_ok_ff;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < IDX_FIELDS; i++) begin
         sum_in = sum_in + SUM_W'(s1_prod_ff[i]);
      end
   end

   always_comb begin
      if (s2_oob_ff)                              status_in = STATUS_RANGE;
      else if (s2_sum_ff >= SUM_W'(MEM_DEPTH))    status_in = STATUS_CAPACITY;
      else                                        status_in = STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= req_acc;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         rsp_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff    <= prod_in;
         s1_oob_ff     <= oob_in;
         s1_mode_ff    <= req_tuser[0];
         s1_wdata_ff   <= req_tdata[IDX_FIELDS*INDEX_W +: WORD_W];
         s2_sum_ff     <= sum_in;
         s2_oob_ff     <= s1_oob_ff;
         s2_mode_ff    <= s1_mode_ff;
         s2_wdata_ff   <= s1_wdata_ff;
         s3_status_ff  <= status_in;
         s3_addr_ff    <= AW'(s2_sum_ff);
         s3_mode_ff    <= s2_mode_ff;
         s3_wdata_ff   <= s2_wdata_ff;
         rsp_status_ff <= s3_status_ff;
         rsp_offset_ff <= (s3_status_ff == STATUS_OK) ? OFFSET_W'(s3_addr_ff) : '0;
         rsp_rd_ok_ff  <= (s3_status_ff == STATUS_OK) && (s3_mode_ff == MODE_READ);
      end
   end

   // ------------------------------------------------------------ element RAM
   // Accesses issue in order, one per cycle while the pipe advances, so a read always sees earlier writes.
   logic                  ram_wr, ram_rd;
   logic [DATA_WIDTH-1:0] ram_rdata;

   assign ram_wr = adv & s3_v_ff & (s3_status_ff == STATUS_OK) & (s3_mode_ff == MODE_WRITE);
   assign ram_rd = adv & s3_v_ff & (s3_status_ff == STATUS_OK) & (s3_mode_ff == MODE_READ);

   mda_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MEM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (s3_addr_ff),
      .wr_data (DATA_WIDTH'(s3_wdata_ff)),
      .rd_en   (ram_rd),
      .rd_addr (s3_addr_ff),
      .rd_data (ram_rdata)
   );

   // ------------------------------------------------------------- response
   logic [WORD_W-1:0] rsp_read_data;

   assign rsp_read_data = rsp_rd_ok_ff ? WORD_W'(ram_rdata) : '0;
   assign rsp_tvalid    = rsp_v_ff;
   assign rsp_tdata     = {{(RSP_DATA_W - RSP_BITS){1'b0}}, rsp_offset_ff,
                           rsp_status_ff, rsp_read_data};

endmodule

// ===== hdl/mda_checker.sv =====
// Port-level checks for multidim_array_access, attached by bind.
// Depends on mda_pkg.
module mda_checker
   import mda_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic                  csr_pready
);

   logic [STATUS_W-1:0] rsp_status;
   logic                cfg_wr;

   assign rsp_status = rsp_tdata[WORD_W +: STATUS_W];
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[CSR_ADDR_W-1:2] <= REG_LENGTH_3);

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_RANGE)
                     || (rsp_status == STATUS_CAPACITY))
      else $error("unknown status code");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status != STATUS_OK)
         |-> (rsp_tdata[WORD_W-1:0] == '0)
             && (rsp_tdata[WORD_W+STATUS_W +: OFFSET_W] == '0))
      else $error("error response carries data or offset");

   // stride rebuild blocks requests right after a register write
   a_cfg_blocks: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> !req_tready)
      else $error("request taken during stride rebuild");

endmodule

bind multidim_array_access mda_checker u_mda_checker (.*);
